// ===== rtl/core/tws_pkg.sv =====
// Shared constants for the three-wire serial byte master.
`timescale 1ns / 1ps

package tws_pkg;

  // Width of the phase timer and the half period register.
  localparam int TIMER_WIDTH = 10;
  localparam int HP_WIDTH    = 10;
  localparam int CMP_WIDTH   = ((TIMER_WIDTH > HP_WIDTH) ? TIMER_WIDTH : HP_WIDTH) + 1;

  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [HP_WIDTH-1:0]    HP_RESET  = HP_WIDTH'(100);
  localparam logic [HP_WIDTH-1:0]    HP_ONE    = HP_WIDTH'(1);

  // Configuration port.
  localparam int PADDR_WIDTH = 3;
  localparam logic [PADDR_WIDTH-1:0] ADDR_HALF_PERIOD = '0;

  // Sequencer phases.
  localparam int PH_WIDTH = 3;
  localparam logic [PH_WIDTH-1:0] PH_IDLE    = 3'd0;
  localparam logic [PH_WIDTH-1:0] PH_ADDR_LO = 3'd1;
  localparam logic [PH_WIDTH-1:0] PH_ADDR_HI = 3'd2;
  localparam logic [PH_WIDTH-1:0] PH_WR_LO   = 3'd3;
  localparam logic [PH_WIDTH-1:0] PH_WR_HI   = 3'd4;
  localparam logic [PH_WIDTH-1:0] PH_TURN    = 3'd5;
  localparam logic [PH_WIDTH-1:0] PH_RD_LO   = 3'd6;
  localparam logic [PH_WIDTH-1:0] PH_RD_HI   = 3'd7;

  localparam logic [2:0] LAST_BIT = 3'd7;

  // Levels of the serial pins.
  typedef struct packed {
    logic ce;
    logic clk;
    logic dout;
    logic drive;
  } pins_t;

  localparam pins_t PINS_IDLE = '{ce: 1'b0, clk: 1'b0, dout: 1'b0, drive: 1'b1};

endpackage

// ===== rtl/core/three_wire_serial_byte_master.sv =====
// Top level of the three-wire serial byte master: sequencer, config register, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall   start_req, opcode, address, write_data, dio_in
// out_      output     out_valid / out_stall chip_enable, serial_clock, dio_out, dio_drive,
//                                            busy_res, done_res, read_data
// cfg       APB        psel/penable/pready   half_period at byte address 0
//
// Each input transfer is one tick of the serial sequencer and yields exactly one result
// transfer. The sequencer state and the result register both update at the edge that
// accepts the tick, so the block sustains one transfer per clock cycle; the single result
// register is the only thing that can hold it back.
// The input is stalled only while the result register is full and the output is stalled.
// Reset (rst_n low, synchronous) returns the sequencer to idle with chip enable low, clock
// low and the data pin driven low, and loads a half period of 100 ticks.
// Stalls on either side never drop, repeat or reorder results, because the sequencer only
// advances on an accepted input transfer.

module three_wire_serial_byte_master (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_start_req,
  input  logic                              in_opcode,
  input  logic [7:0]                        in_address,
  input  logic [7:0]                        in_write_data,
  input  logic                              in_dio_in,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_chip_enable,
  output logic                              out_serial_clock,
  output logic                              out_dio_out,
  output logic                              out_dio_drive,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [7:0]                        out_read_data,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tws_pkg::PADDR_WIDTH-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration register.
  logic [tws_pkg::HP_WIDTH-1:0] half_period_r;
  logic                         cfg_wr;

  // Sequencer state.
  logic [tws_pkg::PH_WIDTH-1:0]    phase_r,  phase_nxt;
  logic [2:0]                      bit_r,    bit_nxt;
  logic [7:0]                      addr_r,   addr_nxt;
  logic [7:0]                      data_r,   data_nxt;
  logic [tws_pkg::TIMER_WIDTH-1:0] timer_r,  timer_nxt;
  logic                            rmode_r,  rmode_nxt;
  tws_pkg::pins_t                  pins_r,   pins_nxt;
  logic [7:0]                      held_r,   held_nxt;
  logic                            done_nxt;

  // Result register.
  logic       out_valid_r;
  logic       out_ce_r, out_clk_r, out_dout_r, out_drive_r, out_busy_r, out_done_r;
  logic [7:0] out_rdata_r;

  logic                             accept;
  logic [tws_pkg::HP_WIDTH-1:0]     hp_eff;
  logic [tws_pkg::CMP_WIDTH-1:0]    timer_inc;
  logic [tws_pkg::CMP_WIDTH-1:0]    hp_ext;
  logic                             keep_phase;
  logic [2:0]                       bit_inc;

  // ---------------------------------------------------------------------------------------
  // Configuration port. A write lands in the access cycle; reads of address 0 return the register, others read zero.
  // ---------------------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == tws_pkg::ADDR_HALF_PERIOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= tws_pkg::HP_RESET;
    end else if (cfg_wr) begin
      half_period_r <= pwdata[tws_pkg::HP_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == tws_pkg::ADDR_HALF_PERIOD) begin
      prdata = 32'(half_period_r);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Handshake. The result register frees up in the same cycle it is drained.
  // ---------------------------------------------------------------------------------------
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------------------
  // Phase timing. A zero half period counts as one tick, and a phase also ends when the
  // timer saturates.
  // ---------------------------------------------------------------------------------------
  assign hp_eff     = (half_period_r == '0) ? tws_pkg::HP_ONE : half_period_r;
  assign timer_inc  = tws_pkg::CMP_WIDTH'(timer_r) + tws_pkg::CMP_WIDTH'(1);
  assign hp_ext     = tws_pkg::CMP_WIDTH'(hp_eff);
  assign keep_phase = (timer_inc < hp_ext) && (timer_r != tws_pkg::TIMER_MAX);
  assign bit_inc    = bit_r + 3'd1;

  // ---------------------------------------------------------------------------------------
  // Sequencer next state for one tick.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    addr_nxt  = addr_r;
    data_nxt  = data_r;
    timer_nxt = timer_r;
    rmode_nxt = rmode_r;
    pins_nxt  = pins_r;
    held_nxt  = held_r;
    done_nxt  = 1'b0;

    if (phase_r == tws_pkg::PH_IDLE) begin
      // A start is honored only here, so starts during a transfer are dropped.
      if (in_start_req) begin
        addr_nxt       = in_address;
        data_nxt       = in_write_data;
        rmode_nxt      = in_opcode;
        bit_nxt        = '0;
        timer_nxt      = '0;
        phase_nxt      = tws_pkg::PH_ADDR_LO;
        pins_nxt.ce    = 1'b1;
        pins_nxt.clk   = 1'b0;
        pins_nxt.drive = 1'b1;
        pins_nxt.dout  = in_address[0];
      end
    end else if (keep_phase) begin
      timer_nxt = timer_r + tws_pkg::TIMER_WIDTH'(1);
    end else begin
      timer_nxt = '0;
      case (phase_r)
        tws_pkg::PH_ADDR_LO: begin
          phase_nxt    = tws_pkg::PH_ADDR_HI;
          pins_nxt.clk = 1'b1;
        end
        tws_pkg::PH_ADDR_HI: begin
          if (bit_r != tws_pkg::LAST_BIT) begin
            bit_nxt       = bit_inc;
            phase_nxt     = tws_pkg::PH_ADDR_LO;
            pins_nxt.clk  = 1'b0;
            pins_nxt.dout = addr_r[bit_inc];
          end else begin
            bit_nxt = '0;
            if (rmode_r) begin
              // Release the line and hold the clock high for the turnaround.
              phase_nxt      = tws_pkg::PH_TURN;
              pins_nxt.drive = 1'b0;
              pins_nxt.dout  = 1'b0;
            end else begin
              phase_nxt     = tws_pkg::PH_WR_LO;
              pins_nxt.clk  = 1'b0;
              pins_nxt.dout = data_r[0];
            end
          end
        end
        tws_pkg::PH_WR_LO: begin
          phase_nxt    = tws_pkg::PH_WR_HI;
          pins_nxt.clk = 1'b1;
        end
        tws_pkg::PH_WR_HI: begin
          if (bit_r != tws_pkg::LAST_BIT) begin
            bit_nxt       = bit_inc;
            phase_nxt     = tws_pkg::PH_WR_LO;
            pins_nxt.dout = data_r[bit_inc];
          end else begin
            phase_nxt = tws_pkg::PH_TURN;
          end
          pins_nxt.clk = 1'b0;
        end
        tws_pkg::PH_TURN: begin
          if (rmode_r) begin
            phase_nxt    = tws_pkg::PH_RD_LO;
            bit_nxt      = '0;
            data_nxt     = '0;
            pins_nxt.clk = 1'b0;
          end else begin
            phase_nxt = tws_pkg::PH_IDLE;
            bit_nxt   = '0;
            pins_nxt  = tws_pkg::PINS_IDLE;
            done_nxt  = 1'b1;
          end
        end
        tws_pkg::PH_RD_LO: begin
          // The data pin is sampled on the last tick of the clock-low phase.
          data_nxt        = data_r;
          data_nxt[bit_r] = data_r[bit_r] | in_dio_in;
          if (bit_r != tws_pkg::LAST_BIT) begin
            phase_nxt    = tws_pkg::PH_RD_HI;
            pins_nxt.clk = 1'b1;
          end else begin
            held_nxt  = data_nxt;
            phase_nxt = tws_pkg::PH_IDLE;
            bit_nxt   = '0;
            pins_nxt  = tws_pkg::PINS_IDLE;
            done_nxt  = 1'b1;
          end
        end
        tws_pkg::PH_RD_HI: begin
          bit_nxt      = bit_inc;
          phase_nxt    = tws_pkg::PH_RD_LO;
          pins_nxt.clk = 1'b0;
        end
        default: begin
          phase_nxt = tws_pkg::PH_IDLE;
          bit_nxt   = '0;
          pins_nxt  = tws_pkg::PINS_IDLE;
        end
      endcase
    end
  end

  // Sequencer state advances only on an accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tws_pkg::PH_IDLE;
      bit_r   <= '0;
      addr_r  <= '0;
      data_r  <= '0;
      timer_r <= '0;
      rmode_r <= 1'b0;
      pins_r  <= tws_pkg::PINS_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      addr_r  <= addr_nxt;
      data_r  <= data_nxt;
      timer_r <= timer_nxt;
      rmode_r <= rmode_nxt;
      pins_r  <= pins_nxt;
      held_r  <= held_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result register: the pin levels after this tick, busy, the done pulse and the held byte.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ce_r    <= pins_nxt.ce;
      out_clk_r   <= pins_nxt.clk;
      out_dout_r  <= pins_nxt.dout && pins_nxt.drive;
      out_drive_r <= pins_nxt.drive;
      out_busy_r  <= (phase_nxt != tws_pkg::PH_IDLE);
      out_done_r  <= done_nxt;
      out_rdata_r <= held_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chip_enable  = out_ce_r;
  assign out_serial_clock = out_clk_r;
  assign out_dio_out      = out_dout_r;
  assign out_dio_drive    = out_drive_r;
  assign out_busy_res     = out_busy_r;
  assign out_done_res     = out_done_r;
  assign out_read_data    = out_rdata_r;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------

  // A finishing transfer leaves the bus idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (!out_ce_r && !out_busy_r && !out_clk_r))
    else $error("done reported while the bus is not idle");

  // A released data line never shows a driven level.
  a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_drive_r) |-> !out_dout_r)
    else $error("data level reported while the line is released");

  // The idle sequencer holds the idle pin levels.
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tws_pkg::PH_IDLE) |-> (!pins_r.ce && !pins_r.clk && pins_r.drive))
    else $error("idle sequencer with active pins");

  // Chip enable is high exactly while a transfer is in progress.
  a_ce_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ce_r == out_busy_r))
    else $error("chip enable and busy disagree");

endmodule
